[rtl/triangle_geometry_setup_macros.svh]
// assertion macros for the triangle geometry setup block
`ifndef TRIANGLE_GEOMETRY_SETUP_MACROS_SVH
`define TRIANGLE_GEOMETRY_SETUP_MACROS_SVH
`ifndef SYNTHESIS
// checked out of reset only
`define TGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define TGS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TGS_ASSERT(lbl, prop, msg)
`define TGS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/tgs_pkg.sv]
// shared constants and types of the triangle geometry setup block
package tgs_pkg;

  localparam int unsigned COORD_WIDTH = 24;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned COMP_W      = 24;
  localparam int unsigned MAG_W       = 40;
  localparam int unsigned UNIT_SHIFT  = 16;
  localparam int unsigned QUOT_W      = UNIT_SHIFT + 2;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned OUT_W       = 3 * COMP_W + MAG_W;
  localparam int unsigned USER_W      = KIND_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CENTROID = 3'd0,
    KIND_EDGE21   = 3'd1,
    KIND_EDGE32   = 3'd2,
    KIND_EDGE13   = 3'd3,
    KIND_NORMAL   = 3'd4
  } kind_e;

  // per-vector control travelling down the pipeline
  typedef struct packed {
    kind_e                   kind;
    logic                    last;
    logic [2:0]              neg;
    logic [2:0][COMP_W-1:0]  cent;
  } tgs_ctl_t;

endpackage

[rtl/tgs_front.sv]
// input register, edge and cross-product setup, and five-slot vector sequencer
module tgs_front import tgs_pkg::*; #(
  parameter  int unsigned CoordWidth = COORD_WIDTH,
  localparam int unsigned InWidth    = ((9 * CoordWidth + 7) / 8) * 8,
  localparam int unsigned VecWidth   = 2 * CoordWidth + 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [InWidth-1:0]         data_i,
  output logic                       valid_o,
  output tgs_ctl_t                   ctl_o,
  output logic [2:0][VecWidth-1:0]   mag_o
);

  localparam int unsigned EdgeW      = CoordWidth + 1;
  localparam int unsigned ProdW      = 2 * CoordWidth + 2;
  localparam int unsigned CrossW     = 2 * CoordWidth + 3;
  localparam int unsigned SumW       = CoordWidth + 2;
  localparam int unsigned CentW      = CoordWidth + 1;
  localparam int unsigned RecipShift = CoordWidth + 3;
  localparam logic [63:0] RecipWide  = ((64'd1 << RecipShift) + 64'd2) / 64'd3;
  localparam logic [RecipShift-1:0] RecipThird = RecipWide[RecipShift-1:0];
  localparam logic [63:0] CompMaxPos = (64'd1 << (COMP_W - 1)) - 64'd1;
  localparam logic [63:0] CompMaxNeg = (64'd1 << (COMP_W - 1));

  logic signed [CoordWidth-1:0] vert [3][3];
  logic signed [EdgeW-1:0]      edge_d [3][3];
  logic signed [EdgeW-1:0]      edge_q [3][3];
  logic signed [ProdW-1:0]      prod_d [6];
  logic signed [ProdW-1:0]      prod_q [6];
  logic signed [SumW-1:0]       csum [3];
  logic [SumW-1:0]              cabs [3];
  logic [CentW-1:0]             cn_d [3];
  logic [CentW-1:0]             cn_q [3];
  logic [2:0]                   cneg_d;
  logic [2:0]                   cneg_q;
  logic                         p_valid_q;
  kind_e                        slot_q;
  kind_e                        slot_next;
  logic                         accept;

  logic [CentW+RecipShift-1:0]  cprod [3];
  logic [63:0]                  cquo [3];
  logic signed [CrossW-1:0]     xprod [3];
  logic [CrossW-1:0]            xprod_abs [3];
  logic [1:0]                   eidx;
  logic [EdgeW:0]               eabs;

  // unpack vertices, form edges, cross products and centroid sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        vert[i][k] = signed'(data_i[(3*i+k)*CoordWidth +: CoordWidth]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      edge_d[0][k] = EdgeW'(vert[1][k]) - EdgeW'(vert[0][k]);
      edge_d[1][k] = EdgeW'(vert[2][k]) - EdgeW'(vert[1][k]);
      edge_d[2][k] = EdgeW'(vert[0][k]) - EdgeW'(vert[2][k]);
      csum[k]   = SumW'(vert[0][k]) + SumW'(vert[1][k]) + SumW'(vert[2][k]);
      cneg_d[k] = csum[k][SumW-1];
      cabs[k]   = cneg_d[k] ? SumW'(-csum[k]) : SumW'(csum[k]);
      cn_d[k]   = CentW'(cabs[k]) + CentW'(1);
    end
    // normal = edge13 x edge21
    prod_d[0] = edge_d[2][1] * edge_d[0][2];
    prod_d[1] = edge_d[2][2] * edge_d[0][1];
    prod_d[2] = edge_d[2][2] * edge_d[0][0];
    prod_d[3] = edge_d[2][0] * edge_d[0][2];
    prod_d[4] = edge_d[2][0] * edge_d[0][1];
    prod_d[5] = edge_d[2][1] * edge_d[0][0];
  end

  assign ready_o = en_i && (!p_valid_q || (slot_q == KIND_NORMAL));
  assign accept  = valid_i && ready_o;
  assign valid_o = p_valid_q;

  // triangle holding register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      edge_q <= edge_d;
      prod_q <= prod_d;
      cn_q   <= cn_d;
      cneg_q <= cneg_d;
    end
  end

  // slot sequence
  always_comb begin
    case (slot_q)
      KIND_CENTROID: slot_next = KIND_EDGE21;
      KIND_EDGE21:   slot_next = KIND_EDGE32;
      KIND_EDGE32:   slot_next = KIND_EDGE13;
      KIND_EDGE13:   slot_next = KIND_NORMAL;
      default:       slot_next = KIND_CENTROID;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      slot_q    <= KIND_CENTROID;
    end else if (en_i) begin
      if (accept) begin
        p_valid_q <= 1'b1;
        slot_q    <= KIND_CENTROID;
      end else if (p_valid_q) begin
        if (slot_q == KIND_NORMAL) begin
          p_valid_q <= 1'b0;
        end
        slot_q <= slot_next;
      end
    end
  end

  // vector for the current slot
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cprod[k]     = CentW'(cn_q[k]) * (CentW+RecipShift)'(RecipThird);
      cquo[k]      = 64'(cprod[k][RecipShift +: CentW]);
      xprod[k]     = CrossW'(prod_q[2*k]) - CrossW'(prod_q[2*k+1]);
      xprod_abs[k] = xprod[k][CrossW-1] ? CrossW'(-xprod[k]) : CrossW'(xprod[k]);
    end
    ctl_o      = '0;
    ctl_o.kind = slot_q;
    ctl_o.last = (slot_q == KIND_NORMAL);
    mag_o      = '0;
    eidx       = 2'd0;
    eabs       = '0;
    case (slot_q)
      KIND_CENTROID: begin
        for (int k = 0; k < 3; k++) begin
          if (!cneg_q[k] && (cquo[k] > CompMaxPos)) begin
            ctl_o.cent[k] = COMP_W'(CompMaxPos);
          end else if (cneg_q[k] && (cquo[k] > CompMaxNeg)) begin
            ctl_o.cent[k] = COMP_W'(CompMaxNeg);
          end else begin
            ctl_o.cent[k] = cneg_q[k] ? COMP_W'(-cquo[k]) : COMP_W'(cquo[k]);
          end
        end
      end
      KIND_EDGE21, KIND_EDGE32, KIND_EDGE13: begin
        if (slot_q == KIND_EDGE21) begin
          eidx = 2'd0;
        end else if (slot_q == KIND_EDGE32) begin
          eidx = 2'd1;
        end else begin
          eidx = 2'd2;
        end
        for (int k = 0; k < 3; k++) begin
          ctl_o.neg[k] = edge_q[eidx][k][EdgeW-1];
          eabs = ctl_o.neg[k] ? (EdgeW+1)'(-(EdgeW+1)'(edge_q[eidx][k]))
                              : (EdgeW+1)'(edge_q[eidx][k]);
          mag_o[k] = VecWidth'(eabs);
        end
      end
      KIND_NORMAL: begin
        for (int k = 0; k < 3; k++) begin
          ctl_o.neg[k] = xprod[k][CrossW-1];
          mag_o[k]     = VecWidth'(xprod_abs[k]);
        end
      end
      default: begin
        mag_o = '0;
      end
    endcase
  end

endmodule

[rtl/tgs_norm.sv]
// squares, sum of squares and pipelined integer square root, one bit a stage
module tgs_norm import tgs_pkg::*; #(
  parameter  int unsigned CoordWidth = COORD_WIDTH,
  localparam int unsigned VecWidth   = 2 * CoordWidth + 2,
  localparam int unsigned RootWidth  = VecWidth + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  tgs_ctl_t                   ctl_i,
  input  logic [2:0][VecWidth-1:0]   mag_i,
  output logic                       valid_o,
  output tgs_ctl_t                   ctl_o,
  output logic [2:0][VecWidth-1:0]   mag_o,
  output logic [RootWidth-1:0]       root_o
);

  localparam int unsigned LoW  = (VecWidth + 1) / 2;
  localparam int unsigned HiW  = VecWidth - LoW;
  localparam int unsigned SqW  = 2 * VecWidth;
  localparam int unsigned SumW = 2 * VecWidth + 2;
  localparam int unsigned RemW = RootWidth + 2;

  // stage a: partial products of each square
  logic                       a_valid_q;
  tgs_ctl_t                   a_ctl_q;
  logic [2:0][VecWidth-1:0]   a_mag_q;
  logic [2*HiW-1:0]           a_hh_q [3];
  logic [HiW+LoW-1:0]         a_hl_q [3];
  logic [2*LoW-1:0]           a_ll_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ctl_q <= ctl_i;
      a_mag_q <= mag_i;
      for (int k = 0; k < 3; k++) begin
        a_hh_q[k] <= mag_i[k][VecWidth-1:LoW] * mag_i[k][VecWidth-1:LoW];
        a_hl_q[k] <= mag_i[k][VecWidth-1:LoW] * mag_i[k][LoW-1:0];
        a_ll_q[k] <= mag_i[k][LoW-1:0] * mag_i[k][LoW-1:0];
      end
    end
  end

  // stage b: assemble the squares
  logic                       b_valid_q;
  tgs_ctl_t                   b_ctl_q;
  logic [2:0][VecWidth-1:0]   b_mag_q;
  logic [SqW-1:0]             b_sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_ctl_q <= a_ctl_q;
      b_mag_q <= a_mag_q;
      for (int k = 0; k < 3; k++) begin
        b_sq_q[k] <= (SqW'(a_hh_q[k]) << (2 * LoW)) + (SqW'(a_hl_q[k]) << (LoW + 1))
                   + SqW'(a_ll_q[k]);
      end
    end
  end

  // root pipeline, entry zero holds the sum of squares
  logic                       sq_valid_q [RootWidth+1];
  tgs_ctl_t                   sq_ctl_q   [RootWidth+1];
  logic [2:0][VecWidth-1:0]   sq_mag_q   [RootWidth+1];
  logic [SumW-1:0]            sq_sum_q   [RootWidth+1];
  logic [RemW-1:0]            sq_rem_q   [RootWidth+1];
  logic [RootWidth-1:0]       sq_root_q  [RootWidth+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q[0] <= 1'b0;
    end else if (en_i) begin
      sq_valid_q[0] <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_ctl_q[0]  <= b_ctl_q;
      sq_mag_q[0]  <= b_mag_q;
      sq_sum_q[0]  <= SumW'(b_sq_q[0]) + SumW'(b_sq_q[1]) + SumW'(b_sq_q[2]);
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  for (genvar g = 1; g <= RootWidth; g++) begin : g_root
    logic [RemW+1:0]      trial;
    logic [RemW+1:0]      tst;
    logic                 ge;

    // one root bit from the next pair of radicand bits
    always_comb begin
      trial = {sq_rem_q[g-1], sq_sum_q[g-1][SumW+1-2*g -: 2]};
      tst   = (RemW+2)'({sq_root_q[g-1], 2'b01});
      ge    = (trial >= tst);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[g] <= 1'b0;
      end else if (en_i) begin
        sq_valid_q[g] <= sq_valid_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_ctl_q[g]  <= sq_ctl_q[g-1];
        sq_mag_q[g]  <= sq_mag_q[g-1];
        sq_sum_q[g]  <= sq_sum_q[g-1];
        sq_rem_q[g]  <= ge ? RemW'(trial - tst) : RemW'(trial);
        sq_root_q[g] <= {sq_root_q[g-1][RootWidth-2:0], ge};
      end
    end
  end

  assign valid_o = sq_valid_q[RootWidth];
  assign ctl_o   = sq_ctl_q[RootWidth];
  assign mag_o   = sq_mag_q[RootWidth];
  assign root_o  = sq_root_q[RootWidth];

endmodule

[rtl/tgs_div.sv]
// magnitude scaling and pipelined restoring division into rounded unit components
module tgs_div import tgs_pkg::*; #(
  parameter  int unsigned CoordWidth = COORD_WIDTH,
  parameter  int unsigned FracBits   = FRAC_BITS,
  localparam int unsigned VecWidth   = 2 * CoordWidth + 2,
  localparam int unsigned RootWidth  = VecWidth + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  tgs_ctl_t                   ctl_i,
  input  logic [2:0][VecWidth-1:0]   mag_i,
  input  logic [RootWidth-1:0]       root_i,
  output logic                       valid_o,
  output kind_e                      kind_o,
  output logic                       last_o,
  output logic [2:0][COMP_W-1:0]     comp_o,
  output logic [MAG_W-1:0]           magnitude_o,
  output logic                       degenerate_o
);

  localparam int unsigned DivW = RootWidth + QUOT_W;

  logic [RootWidth-1:0] scaled;
  logic [MAG_W-1:0]     mag_sat;

  // reported magnitude, saturated to the output width
  assign scaled = (ctl_i.kind == KIND_NORMAL) ? (root_i >> FracBits) : root_i;

  if (RootWidth > MAG_W) begin : g_sat
    assign mag_sat = (|scaled[RootWidth-1:MAG_W]) ? '1 : scaled[MAG_W-1:0];
  end else begin : g_nosat
    assign mag_sat = MAG_W'(scaled);
  end

  // division pipeline, entry zero holds the scaled operands
  logic                    dv_valid_q [QUOT_W+1];
  tgs_ctl_t                dv_ctl_q   [QUOT_W+1];
  logic [RootWidth-1:0]    dv_root_q  [QUOT_W+1];
  logic [MAG_W-1:0]        dv_mag_q   [QUOT_W+1];
  logic                    dv_degen_q [QUOT_W+1];
  logic [2:0][DivW-1:0]    dv_rem_q   [QUOT_W+1];
  logic [2:0][QUOT_W-1:0]  dv_quo_q   [QUOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_ctl_q[0]   <= ctl_i;
      dv_root_q[0]  <= root_i;
      dv_mag_q[0]   <= (ctl_i.kind == KIND_CENTROID) ? '0 : mag_sat;
      dv_degen_q[0] <= (ctl_i.kind != KIND_CENTROID) && (scaled == '0);
      dv_quo_q[0]   <= '0;
      for (int k = 0; k < 3; k++) begin
        dv_rem_q[0][k] <= DivW'(mag_i[k]) << UNIT_SHIFT;
      end
    end
  end

  for (genvar d = 1; d <= QUOT_W; d++) begin : g_step
    localparam int unsigned Bit = QUOT_W - d;
    logic [DivW-1:0]         tst;
    logic [2:0][DivW-1:0]    rem_d;
    logic [2:0][QUOT_W-1:0]  quo_d;

    // one quotient bit per lane
    always_comb begin
      tst   = DivW'(dv_root_q[d-1]) << Bit;
      rem_d = dv_rem_q[d-1];
      quo_d = dv_quo_q[d-1];
      for (int k = 0; k < 3; k++) begin
        if (dv_rem_q[d-1][k] >= tst) begin
          rem_d[k]      = dv_rem_q[d-1][k] - tst;
          quo_d[k][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[d] <= 1'b0;
      end else if (en_i) begin
        dv_valid_q[d] <= dv_valid_q[d-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_ctl_q[d]   <= dv_ctl_q[d-1];
        dv_root_q[d]  <= dv_root_q[d-1];
        dv_mag_q[d]   <= dv_mag_q[d-1];
        dv_degen_q[d] <= dv_degen_q[d-1];
        dv_rem_q[d]   <= rem_d;
        dv_quo_q[d]   <= quo_d;
      end
    end
  end

  // round to nearest, apply sign, pick centroid or unit vector
  logic [QUOT_W:0] rounded [3];
  tgs_ctl_t        fin_ctl;

  assign fin_ctl = dv_ctl_q[QUOT_W];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rounded[k] = (QUOT_W+1)'(dv_quo_q[QUOT_W][k])
                 + (QUOT_W+1)'({dv_rem_q[QUOT_W][k], 1'b0} >=
                               (DivW+1)'(dv_root_q[QUOT_W]));
      if (fin_ctl.kind == KIND_CENTROID) begin
        comp_o[k] = fin_ctl.cent[k];
      end else if (dv_degen_q[QUOT_W]) begin
        comp_o[k] = '0;
      end else if (fin_ctl.neg[k]) begin
        comp_o[k] = COMP_W'(-COMP_W'(rounded[k]));
      end else begin
        comp_o[k] = COMP_W'(rounded[k]);
      end
    end
  end

  assign valid_o      = dv_valid_q[QUOT_W];
  assign kind_o       = fin_ctl.kind;
  assign last_o       = fin_ctl.last;
  assign magnitude_o  = dv_mag_q[QUOT_W];
  assign degenerate_o = dv_degen_q[QUOT_W];

endmodule

[rtl/triangle_geometry_setup.sv]
// Triangle geometry setup: centroid, edge unit vectors and unit normal.
// Slave channel: one transaction carries a triangle, nine signed coordinates
// of CoordWidth bits (FracBits fraction bits) packed in s_axis_tdata_i.
// Master channel: each triangle yields five transactions in order: centroid,
// edge 2-1, edge 3-2, edge 1-3 and normal; tlast marks the normal, tuser
// carries the kind and the degenerate flag.
// Throughput: one result per cycle while the receiver does not stall; the input
// register hands out one vector a cycle, unless stalled, to a single shared pipeline.
// A result passes the front register, stages a and b, the sum register, the
// one-bit-a-stage square root (2*CoordWidth+3 stages), the divider operand
// register, the 18-stage divider and the output register.
// Reset clears every valid bit and the slot sequencer; no other state is reset.
// When the receiver stalls, the output register holds its transaction and the
// whole pipeline freezes, so nothing is lost or repeated; s_axis_tready_o
// drops in the same cycle.
`include "triangle_geometry_setup_macros.svh"
module triangle_geometry_setup import tgs_pkg::*; #(
  parameter  int unsigned CoordWidth = COORD_WIDTH,
  parameter  int unsigned FracBits   = FRAC_BITS,
  localparam int unsigned InWidth    = ((9 * CoordWidth + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, zero fill
  input  logic [InWidth-1:0] s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // comp_x, comp_y, comp_z, magnitude
  output logic [OUT_W-1:0]   m_axis_tdata_o,
  // kind, degenerate
  output logic [USER_W-1:0]  m_axis_tuser_o,
  output logic               m_axis_tlast_o
);

  localparam int unsigned VecWidth  = 2 * CoordWidth + 2;
  localparam int unsigned RootWidth = VecWidth + 1;

  logic                       pipe_en;
  logic                       fr_valid;
  tgs_ctl_t                   fr_ctl;
  logic [2:0][VecWidth-1:0]   fr_mag;
  logic                       nm_valid;
  tgs_ctl_t                   nm_ctl;
  logic [2:0][VecWidth-1:0]   nm_mag;
  logic [RootWidth-1:0]       nm_root;
  logic                       dv_valid;
  kind_e                      dv_kind;
  logic                       dv_last;
  logic [2:0][COMP_W-1:0]     dv_comp;
  logic [MAG_W-1:0]           dv_magnitude;
  logic                       dv_degen;

  logic                       out_valid_q;
  logic [OUT_W-1:0]           out_data_q;
  logic [USER_W-1:0]          out_user_q;
  logic                       out_last_q;

  // the pipeline advances whenever the output register can take a result
  assign pipe_en = !out_valid_q || m_axis_tready_i;

  tgs_front #(
    .CoordWidth(CoordWidth)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (fr_valid),
    .ctl_o   (fr_ctl),
    .mag_o   (fr_mag)
  );

  tgs_norm #(
    .CoordWidth(CoordWidth)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (fr_valid),
    .ctl_i   (fr_ctl),
    .mag_i   (fr_mag),
    .valid_o (nm_valid),
    .ctl_o   (nm_ctl),
    .mag_o   (nm_mag),
    .root_o  (nm_root)
  );

  tgs_div #(
    .CoordWidth(CoordWidth),
    .FracBits  (FracBits)
  ) u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (pipe_en),
    .valid_i      (nm_valid),
    .ctl_i        (nm_ctl),
    .mag_i        (nm_mag),
    .root_i       (nm_root),
    .valid_o      (dv_valid),
    .kind_o       (dv_kind),
    .last_o       (dv_last),
    .comp_o       (dv_comp),
    .magnitude_o  (dv_magnitude),
    .degenerate_o (dv_degen)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_data_q <= {dv_magnitude, dv_comp[2], dv_comp[1], dv_comp[0]};
      out_user_q <= {dv_degen, dv_kind};
      out_last_q <= dv_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  `TGS_ASSERT_RST(a_reset_quiet, !rst_ni |-> !m_axis_tvalid_o, "result shown during reset")
  `TGS_ASSERT(a_ready_needs_room, s_axis_tready_o |-> pipe_en, "input taken while stalled")
  `TGS_ASSERT(a_last_is_normal, m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[KIND_W-1:0] == KIND_NORMAL, "tlast on a result other than the normal")
  `TGS_ASSERT(a_centroid_clean, m_axis_tvalid_o && m_axis_tuser_o[KIND_W-1:0] == KIND_CENTROID |-> m_axis_tdata_o[OUT_W-1 -: MAG_W] == '0 && !m_axis_tuser_o[KIND_W], "centroid with magnitude or degenerate flag")
  `TGS_ASSERT(a_degen_zero, m_axis_tvalid_o && m_axis_tuser_o[KIND_W] |-> m_axis_tdata_o == '0, "degenerate result with nonzero data")

endmodule

[tb/testbench.sv]
// self-checking testbench for the triangle geometry setup block
`timescale 1ns / 1ps

// expected-result store with its own geometry predictor
class triangle_scoreboard;
  typedef logic [8:0][tgs_pkg::COORD_WIDTH-1:0] tri_t;
  typedef struct {
    tgs_pkg::kind_e           kind;
    logic [2:0][23:0]         comp;
    logic [39:0]              magnitude;
    logic                     degenerate;
    logic                     last;
  } geom_result_t;

  geom_result_t expected[$];
  int mismatches;
  int triangles_seen;
  int results_seen;
  int degenerate_seen;

  // floor of the square root, one bit at a time
  static function automatic logic [159:0] root_floor(logic [159:0] s);
    logic [159:0] r;
    logic [159:0] t;
    r = '0;
    for (int k = 70; k >= 0; k--) begin
      t = r | (160'd1 << k);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // length and rounded unit vector from sign and magnitude components
  static function automatic geom_result_t unit_vector(tgs_pkg::kind_e kind,
      logic [2:0][63:0] mags, logic [2:0] neg, int shift, logic last);
    geom_result_t res;
    logic [159:0] sq, norm, scaled, num, quo, rem, a;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      a = mags[i];
      sq += a * a;
    end
    norm = root_floor(sq);
    scaled = norm >> shift;
    res.kind = kind;
    res.last = last;
    res.magnitude = ((scaled >> 40) != 0) ? '1 : scaled[39:0];
    res.degenerate = (scaled == 0);
    for (int i = 0; i < 3; i++) begin
      quo = '0;
      if (!res.degenerate) begin
        num = {96'd0, mags[i]} << 16;
        quo = num / norm;
        rem = num - quo * norm;
        // round half away from zero on the magnitude
        if ((rem << 1) >= norm) quo = quo + 1;
      end
      if (neg[i]) quo = -quo;
      res.comp[i] = quo[23:0];
    end
    return res;
  endfunction

  function void note_triangle(tri_t t);
    longint v[3][3];
    longint e[3][3];
    longint s, q, c;
    longint cr[3];
    logic [2:0][63:0] mags;
    logic [2:0] neg;
    geom_result_t cent;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) v[i][k] = $signed(t[i*3+k]);
    // centroid, rounded to nearest and saturated
    cent.kind = tgs_pkg::KIND_CENTROID;
    cent.magnitude = '0;
    cent.degenerate = 1'b0;
    cent.last = 1'b0;
    for (int k = 0; k < 3; k++) begin
      s = v[0][k] + v[1][k] + v[2][k];
      q = ((s < 0 ? -s : s) + 1) / 3;
      if (s < 0) q = -q;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      cent.comp[k] = q[23:0];
    end
    expected.push_back(cent);
    // edges 2-1, 3-2, 1-3
    for (int k = 0; k < 3; k++) begin
      e[0][k] = v[1][k] - v[0][k];
      e[1][k] = v[2][k] - v[1][k];
      e[2][k] = v[0][k] - v[2][k];
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        mags[k] = e[i][k] < 0 ? -e[i][k] : e[i][k];
        neg[k] = e[i][k] < 0;
      end
      expected.push_back(unit_vector(tgs_pkg::kind_e'(i + 1), mags, neg, 0, 1'b0));
    end
    // normal is edge 1-3 crossed with edge 2-1
    cr[0] = e[2][1] * e[0][2] - e[2][2] * e[0][1];
    cr[1] = e[2][2] * e[0][0] - e[2][0] * e[0][2];
    cr[2] = e[2][0] * e[0][1] - e[2][1] * e[0][0];
    for (int k = 0; k < 3; k++) begin
      c = cr[k];
      mags[k] = c < 0 ? -c : c;
      neg[k] = c < 0;
    end
    expected.push_back(unit_vector(tgs_pkg::KIND_NORMAL, mags, neg,
                                   tgs_pkg::FRAC_BITS, 1'b1));
    triangles_seen++;
  endfunction

  function void check_result(logic [111:0] data, logic [3:0] user, logic last);
    geom_result_t exp_r;
    results_seen++;
    if (expected.size() == 0) begin
      $error("result transaction with nothing expected: kind %0d", user[2:0]);
      mismatches++;
      return;
    end
    exp_r = expected.pop_front();
    if (exp_r.degenerate) degenerate_seen++;
    if (user[2:0] != exp_r.kind) begin
      $error("kind: expected %0d, got %0d", exp_r.kind, user[2:0]);
      mismatches++;
    end
    for (int i = 0; i < 3; i++)
      if (data[i*24 +: 24] != exp_r.comp[i]) begin
        $error("comp_%0d (kind %0d): expected %h, got %h", i, exp_r.kind,
               exp_r.comp[i], data[i*24 +: 24]);
        mismatches++;
      end
    if (data[111:72] != exp_r.magnitude) begin
      $error("magnitude (kind %0d): expected %h, got %h", exp_r.kind,
             exp_r.magnitude, data[111:72]);
      mismatches++;
    end
    if (user[3] != exp_r.degenerate) begin
      $error("degenerate (kind %0d): expected %0b, got %0b", exp_r.kind,
             exp_r.degenerate, user[3]);
      mismatches++;
    end
    if (last != exp_r.last) begin
      $error("last (kind %0d): expected %0b, got %0b", exp_r.kind, exp_r.last, last);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  import tgs_pkg::*;

  typedef logic [8:0][COORD_WIDTH-1:0] tri_t;
  localparam int CycleLimit = 400000;
  localparam int RandomTriangles = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z
  logic [215:0]       s_axis_tdata_i = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  // comp_x, comp_y, comp_z, magnitude
  logic [OUT_W-1:0]   m_axis_tdata_o;
  // kind, degenerate
  logic [USER_W-1:0]  m_axis_tuser_o;
  logic               m_axis_tlast_o;

  triangle_scoreboard sb = new();
  bit  calm = 1'b0;
  int  cycles = 0;
  int  ready_hold = 0;

  triangle_geometry_setup uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .m_axis_tuser_o, .m_axis_tlast_o
  );

  // clock
  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // transaction monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.note_triangle(s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (m_axis_tready_i) begin
      ready_hold <= idle_len();
      m_axis_tready_i <= (ready_hold == 0) ? 1'b0 : 1'b1;
    end else begin
      m_axis_tready_i <= 1'b1;
      ready_hold <= calm ? 20 : $urandom_range(12);
    end
  end

  task automatic send_triangle(tri_t t);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= t;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($urandom());
      1: return 24'($signed($urandom_range(32768)) - 16384);
      default: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  function automatic tri_t vertices(logic [23:0] ax, logic [23:0] ay, logic [23:0] az,
      logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
      logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
    return {cz, cy, cx, bz, by, bx, az, ay, ax};
  endfunction

  initial begin
    tri_t t;
    int mode;
    logic [23:0] one;
    logic [23:0] zero;
    rst_ni <= 1'b0;
    one = 24'h001000;
    zero = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    calm = 1'b1;
    send_triangle('0);
    send_triangle('1);
    send_triangle({9{24'h7FFFFF}});
    send_triangle({9{24'h800000}});
    send_triangle(vertices(24'h800000, 24'h800000, 24'h800000,
                           24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                           24'h800000, 24'h7FFFFF, 24'h7FFFFF));
    send_triangle(vertices(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                           24'h800000, 24'h7FFFFF, 24'h800000,
                           24'h7FFFFF, 24'h800000, 24'h800000));
    // unit right triangle, and its mirror image
    send_triangle(vertices(zero, zero, zero, one, zero, zero, zero, one, zero));
    send_triangle(vertices(zero, zero, zero, zero, one, zero, one, zero, zero));
    // tiny area whose magnitude truncates to zero
    send_triangle(vertices(zero, zero, zero, 24'd1, zero, zero, zero, 24'd1, zero));
    send_triangle(vertices(24'hFFFFFF, zero, 24'd5, zero, zero, 24'd5,
                           24'hFFFFFF, 24'd1, 24'd5));
    // repeated vertex and collinear points
    send_triangle(vertices(24'h123456, 24'hABCDEF, 24'h000777,
                           24'h123456, 24'hABCDEF, 24'h000777,
                           24'h000100, 24'h000200, 24'h000300));
    send_triangle(vertices(zero, zero, zero, one, one, one,
                           24'h002000, 24'h002000, 24'h002000));
    // centroid rounding both ways
    send_triangle(vertices(24'd1, 24'hFFFFFF, 24'd2, zero, zero, zero,
                           zero, zero, 24'hFFFFFF));
    send_triangle(vertices(24'd2, 24'hFFFFFE, 24'd4, zero, zero, zero,
                           zero, zero, 24'hFFFFFD));
    // equal-length edges, rounding of unit components near a half
    send_triangle(vertices(24'd3, 24'd4, zero, zero, zero, zero, zero, 24'd3, 24'd4));
    send_triangle(vertices(24'h5A5A5A, 24'hA5A5A5, 24'h3C3C3C,
                           24'hC3C3C3, 24'h0F0F0F, 24'hF0F0F0,
                           24'h333333, 24'hCCCCCC, 24'h555555));
    drain_results();
    calm = 1'b0;

    // random triangles: full range, small, saturated extremes, degenerate
    for (int n = 0; n < RandomTriangles; n++) begin
      if (n == 150) begin
        drain_results();
        calm = 1'b1;
      end
      if (n == 190) calm = 1'b0;
      mode = $urandom_range(99);
      for (int j = 0; j < 9; j++)
        t[j] = rand_coord(mode < 50 ? 0 : (mode < 85 ? 1 : 2));
      if (mode >= 92) begin
        // third vertex on the line through the first two, or a repeat
        for (int k = 0; k < 3; k++)
          t[6+k] = (mode & 1) ? t[k] : t[3+k] + (t[3+k] - t[k]);
      end
      send_triangle(t);
    end
    drain_results();
    repeat (120) @(posedge clk_i);

    $display("covered %0d triangles, %0d result transactions, %0d degenerate",
             sb.triangles_seen, sb.results_seen, sb.degenerate_seen);
    $display("with random gaps and stalls on both channels");
    if (sb.mismatches == 0 && sb.expected.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
